@@ rtl/ovle_pkg.sv @@
// Shared types and constants of the ordered value list engine.
`default_nettype none

package ovle_pkg;

    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 3'd0,
        FN_REMOVE = 3'd1,
        FN_COUNT  = 3'd2,
        FN_FIND   = 3'd3,
        FN_MIN    = 3'd4,
        FN_MAX    = 3'd5
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Request traveling down the chain of cells, with its running result
    typedef struct packed {
        logic              busy;
        func_t             func;
        logic [DATA_W-1:0] value;
        logic              hit;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] ext;
    } probe_t;

endpackage

`default_nettype wire

@@ rtl/ovle_req_if.sv @@
// Request channel: operation code and operand.
`default_nettype none

interface ovle_req_if;
    logic                                valid;
    logic                                ready;
    logic [ovle_pkg::FUNC_W-1:0]         func;
    logic signed [ovle_pkg::DATA_W-1:0]  value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

`default_nettype wire

@@ rtl/ovle_rsp_if.sv @@
// Result channel: status, match count and extreme or found value.
`default_nettype none

interface ovle_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [ovle_pkg::STAT_W-1:0]         status;
    logic [ovle_pkg::CNT_W-1:0]          match_count;
    logic signed [ovle_pkg::DATA_W-1:0]  extreme_value;

    modport source (output valid, status, match_count, extreme_value, input ready);
    modport sink   (input valid, status, match_count, extreme_value, output ready);
endinterface

`default_nettype wire

@@ rtl/ovle_cell.sv @@
// One list cell: holds one entry and updates the passing request.
`default_nettype none

module ovle_cell #(
    parameter int IDX   = 0,
    parameter int OCC_W = 7
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire [OCC_W-1:0]                 occ,
    input  wire                             wr_en,
    input  wire [ovle_pkg::DATA_W-1:0]      wr_value,
    input  wire [ovle_pkg::DATA_W-1:0]      nbr_entry,
    output logic [ovle_pkg::DATA_W-1:0]     entry,
    input  ovle_pkg::probe_t                p_in,
    output ovle_pkg::probe_t                p_out
);

    localparam logic [OCC_W-1:0] IDX_C = OCC_W'(IDX);

    logic [ovle_pkg::DATA_W-1:0] entry_reg;
    logic [ovle_pkg::DATA_W-1:0] entry_next;
    ovle_pkg::probe_t            p_reg;
    ovle_pkg::probe_t            p_next;
    logic                        live;
    logic                        match;
    logic                        shift;

    // Update the request with this cell's entry
    always_comb
    begin
        live   = IDX_C < occ;
        match  = live && (entry_reg == p_in.value);
        p_next = p_in;
        shift  = 1'b0;
        case (p_in.func)
            ovle_pkg::FN_REMOVE:
            begin
                if (p_in.busy && live && (match || p_in.hit))
                begin
                    shift      = 1'b1;
                    p_next.hit = 1'b1;
                end
            end
            ovle_pkg::FN_COUNT:
            begin
                if (match && p_in.count < ovle_pkg::COUNT_MAX)
                begin
                    p_next.count = p_in.count + 7'd1;
                end
            end
            ovle_pkg::FN_FIND:
            begin
                if (match && !p_in.hit)
                begin
                    p_next.hit = 1'b1;
                    p_next.ext = entry_reg;
                end
            end
            ovle_pkg::FN_MIN:
            begin
                if (live && (!p_in.hit || $signed(entry_reg) < $signed(p_in.ext)))
                begin
                    p_next.hit = 1'b1;
                    p_next.ext = entry_reg;
                end
            end
            ovle_pkg::FN_MAX:
            begin
                if (live && (!p_in.hit || $signed(entry_reg) > $signed(p_in.ext)))
                begin
                    p_next.hit = 1'b1;
                    p_next.ext = entry_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Take an appended value, or pull up the neighbor's entry to close a gap
    always_comb
    begin
        if (wr_en)
        begin
            entry_next = wr_value;
        end
        else if (shift)
        begin
            entry_next = nbr_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Hand the request to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else
        begin
            p_reg <= p_next;
        end
    end

    assign entry = entry_reg;
    assign p_out = p_reg;

endmodule

`default_nettype wire

@@ rtl/ordered_value_list_engine_unit.sv @@
// Ordered value list engine: request FSM, occupancy and the chain of cells.
//
// Usage: requests arrive on req (func, value) and each gives one result on rsp
// (status, match_count, extreme_value). Both are valid/ready channels; an item
// moves on a clock edge with valid and ready high.
// Append and the unused codes skip the cell row: their result is loaded into the
// output register once it is free, and the block then returns to idle.
// Remove, count, find, minimum and maximum send the request down a row of
// CAPACITY cells, one cell per cycle, each holding one entry; the result is
// captured as the request leaves the last cell, then moved to the output register.
// One request is in flight at a time, so a scanning request occupies the block
// until it has passed the whole cell row and its result has reached the output.
// req.ready is high only while no request is in flight. A result waiting in the
// output register does not block the next request; if the receiver stalls long
// enough, the next result waits in the block and req.ready stays low.
// Reset (rst_n low, asynchronous) empties the list and drops any request or
// result in flight; stored entries are not cleared, and no sweep is needed.
`default_nettype none

module ordered_value_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  wire        clk,
    input  wire        rst_n,
    ovle_req_if.sink   req,
    ovle_rsp_if.source rsp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam logic [OCC_W-1:0] CAP_C = OCC_W'(CAPACITY);

    ovle_pkg::state_t state_reg;
    ovle_pkg::state_t state_next;

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    ovle_pkg::probe_t launch_reg;
    ovle_pkg::probe_t launch_next;

    logic [ovle_pkg::STAT_W-1:0] res_status_reg;
    logic [ovle_pkg::STAT_W-1:0] res_status_next;
    logic [ovle_pkg::CNT_W-1:0]  res_count_reg;
    logic [ovle_pkg::CNT_W-1:0]  res_count_next;
    logic [ovle_pkg::DATA_W-1:0] res_ext_reg;
    logic [ovle_pkg::DATA_W-1:0] res_ext_next;

    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    logic [ovle_pkg::STAT_W-1:0] rsp_status_reg;
    logic [ovle_pkg::STAT_W-1:0] rsp_status_next;
    logic [ovle_pkg::CNT_W-1:0]  rsp_count_reg;
    logic [ovle_pkg::CNT_W-1:0]  rsp_count_next;
    logic [ovle_pkg::DATA_W-1:0] rsp_ext_reg;
    logic [ovle_pkg::DATA_W-1:0] rsp_ext_next;

    logic             accept;
    logic             scan_func;
    logic             out_free;
    logic             app_en;
    ovle_pkg::func_t  req_func;

    ovle_pkg::probe_t            chain [CAPACITY+1];
    logic [ovle_pkg::DATA_W-1:0] ent   [CAPACITY];
    ovle_pkg::probe_t            tail;

    assign req_func  = ovle_pkg::func_t'(req.func);
    assign accept    = req.valid && (state_reg == ovle_pkg::S_IDLE);
    assign scan_func = (req.func == ovle_pkg::FN_REMOVE) || (req.func == ovle_pkg::FN_COUNT)
                    || (req.func == ovle_pkg::FN_FIND) || (req.func == ovle_pkg::FN_MIN)
                    || (req.func == ovle_pkg::FN_MAX);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign app_en    = accept && (req.func == ovle_pkg::FN_APPEND) && (occ_reg < CAP_C);
    assign tail      = chain[CAPACITY];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ovle_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = scan_func ? ovle_pkg::S_SCAN : ovle_pkg::S_DONE;
                end
            end
            ovle_pkg::S_SCAN:
            begin
                if (tail.busy)
                begin
                    state_next = ovle_pkg::S_DONE;
                end
            end
            ovle_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = ovle_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ovle_pkg::S_IDLE;
            end
        endcase
    end

    // Launch, result capture, occupancy and output register
    always_comb
    begin
        req.ready       = (state_reg == ovle_pkg::S_IDLE);
        launch_next     = '0;
        occ_next        = occ_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        res_ext_next    = res_ext_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_ext_next    = rsp_ext_reg;

        case (state_reg)
            ovle_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    launch_next.busy  = scan_func;
                    launch_next.func  = req_func;
                    launch_next.value = req.value;
                    res_status_next   = ovle_pkg::ST_OK;
                    res_count_next    = '0;
                    res_ext_next      = '0;
                    if (req.func == ovle_pkg::FN_APPEND)
                    begin
                        if (app_en)
                        begin
                            occ_next = occ_reg + 1'b1;
                        end
                        else
                        begin
                            res_status_next = ovle_pkg::ST_FULL;
                        end
                    end
                end
            end
            ovle_pkg::S_SCAN:
            begin
                if (tail.busy)
                begin
                    res_status_next = ovle_pkg::ST_OK;
                    res_count_next  = '0;
                    res_ext_next    = '0;
                    case (tail.func)
                        ovle_pkg::FN_REMOVE:
                        begin
                            if (tail.hit)
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                            else
                            begin
                                res_status_next = ovle_pkg::ST_NOT_FOUND;
                            end
                        end
                        ovle_pkg::FN_COUNT:
                        begin
                            res_count_next = tail.count;
                        end
                        ovle_pkg::FN_FIND:
                        begin
                            if (tail.hit)
                            begin
                                res_ext_next = tail.ext;
                            end
                            else
                            begin
                                res_status_next = ovle_pkg::ST_NOT_FOUND;
                            end
                        end
                        ovle_pkg::FN_MIN, ovle_pkg::FN_MAX:
                        begin
                            if (tail.hit)
                            begin
                                res_ext_next = tail.ext;
                            end
                            else
                            begin
                                res_status_next = ovle_pkg::ST_EMPTY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ovle_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_count_next  = res_count_reg;
                    rsp_ext_next    = res_ext_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ovle_pkg::S_IDLE;
            occ_reg       <= '0;
            launch_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        res_ext_reg    <= res_ext_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_ext_reg    <= rsp_ext_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.match_count   = rsp_count_reg;
    assign rsp.extreme_value = rsp_ext_reg;

    assign chain[0] = launch_reg;

    // Row of cells, one entry each
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ovle_pkg::DATA_W-1:0] nbr;
        logic                        wr_en;

        if (i == CAPACITY - 1)
        begin : g_last
            assign nbr = ent[i];
        end
        else
        begin : g_mid
            assign nbr = ent[i+1];
        end

        assign wr_en = app_en && (occ_reg == OCC_W'(i));

        ovle_cell #(
            .IDX   (i),
            .OCC_W (OCC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .occ       (occ_reg),
            .wr_en     (wr_en),
            .wr_value  (req.value),
            .nbr_entry (nbr),
            .entry     (ent[i]),
            .p_in      (chain[i]),
            .p_out     (chain[i+1])
        );
    end

`ifndef ASSERT_OFF
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.busy |-> state_reg == ovle_pkg::S_SCAN)
        else $error("request left the cell row outside a scan");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_C)
        else $error("occupancy above capacity");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ovle_pkg::S_SCAN && tail.busy && tail.func == ovle_pkg::FN_REMOVE
            && tail.hit) |=> occ_reg == $past(occ_reg) - 1'b1)
        else $error("successful remove did not shrink the list");
`endif

endmodule

`default_nettype wire
